>>> sv/sict_pkg.sv
// ----------------------------------------------------------------------------
// sict_pkg - shared types and constants
// Item layouts, operation codes and gate register offsets of the secondary
// CPU interrupt and timer controller.
// ----------------------------------------------------------------------------
package sict_pkg;

   localparam int unsigned TIMER_UNIT_DEF = 385;
   localparam int unsigned MAX_TICK_DEF   = 1023;

   localparam int unsigned OP_W   = 3;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TICK_W = 10;
   localparam int unsigned LVL_W  = 3;
   localparam int unsigned ACC_W  = 17;

   typedef enum logic [OP_W-1:0] {
      OP_MAIN_WRITE = 3'd0,
      OP_SUB_WRITE  = 3'd1,
      OP_READ       = 3'd2,
      OP_TICK       = 3'd3,
      OP_ACK        = 3'd4,
      OP_RAISE      = 3'd5
   } opcode_type;

   localparam logic [BYTE_W-1:0] REG_HOST  = 8'h00;
   localparam logic [BYTE_W-1:0] REG_CTRL  = 8'h01;
   localparam logic [BYTE_W-1:0] REG_TIMER = 8'h31;
   localparam logic [BYTE_W-1:0] REG_MASK  = 8'h33;

   // Bit positions inside the gate registers
   localparam int unsigned CTRL_RUN_BIT  = 0;
   localparam int unsigned CTRL_BUS_BIT  = 1;
   localparam int unsigned HOST_REQ_BIT  = 0;
   localparam int unsigned LVL_HOST      = 2;
   localparam int unsigned LVL_TIMER     = 3;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [BYTE_W-1:0] reg_offset;
      logic [BYTE_W-1:0] write_data;
      logic [TICK_W-1:0] tick_cycles;
      logic [LVL_W-1:0]  irq_level_in;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic [LVL_W-1:0]  irq_level;
      logic              cpu_reset_held;
      logic              cpu_bus_held;
   } rsp_item_type;

endpackage

>>> sv/sict_core.sv
// ----------------------------------------------------------------------------
// sict_core - gate register state and item execution
// Holds control, mask, pending and timer state; executes one item per fire.
// ----------------------------------------------------------------------------
module sict_core #(
   parameter int unsigned TIMER_UNIT = sict_pkg::TIMER_UNIT_DEF,
   parameter int unsigned MAX_TICK   = sict_pkg::MAX_TICK_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  sict_pkg::req_item_type item,
   output sict_pkg::rsp_item_type result
);
   import sict_pkg::*;

   localparam int unsigned PERIOD_W  = $clog2(256 * TIMER_UNIT + 1);
   localparam int unsigned SUM_W     = ((ACC_W > PERIOD_W) ? ACC_W : PERIOD_W) + 1;
   localparam int unsigned MOD_STEPS = MAX_TICK / (2 * TIMER_UNIT) + 1;

   logic [BYTE_W-1:0] host_ff,   host_in;
   logic [BYTE_W-1:0] ctrl_ff,   ctrl_in;
   logic              held_ff,   held_in;
   logic              bus_ff,    bus_in;
   logic [BYTE_W-1:0] mask_ff,   mask_in;
   logic [BYTE_W-1:0] pend_ff,   pend_in;
   logic [BYTE_W-1:0] reload_ff, reload_in;
   logic [ACC_W-1:0]  acc_ff,    acc_in;
   logic [LVL_W-1:0]  level_ff,  level_in;

   logic [BYTE_W-1:0]   rd;
   logic                wr_main;
   logic [TICK_W-1:0]   cyc_sat;
   logic [PERIOD_W-1:0] period;
   logic [SUM_W-1:0]    sum;
   logic [SUM_W-1:0]    rem;

   function automatic logic [LVL_W-1:0] encode(input logic [BYTE_W-1:0] active);
      logic [LVL_W-1:0] lvl;
      lvl = '0;
      for (int i = 1; i <= 6; i++) begin
         if (active[i]) begin
            lvl = LVL_W'(i);
         end
      end
      return lvl;
   endfunction

   // Timer period and bounded remainder of the accumulated cycles
   always_comb begin
      cyc_sat = (item.tick_cycles > TICK_W'(MAX_TICK)) ? TICK_W'(MAX_TICK)
                                                      : item.tick_cycles;
      period  = (PERIOD_W'(reload_ff) + PERIOD_W'(1)) * PERIOD_W'(TIMER_UNIT);
      sum     = SUM_W'(acc_ff) + SUM_W'(cyc_sat);
      rem     = sum;
      for (int i = 0; i < int'(MOD_STEPS); i++) begin
         if (rem >= SUM_W'(period)) begin
            rem = rem - SUM_W'(period);
         end
      end
   end

   always_comb begin
      host_in   = host_ff;
      ctrl_in   = ctrl_ff;
      held_in   = held_ff;
      bus_in    = bus_ff;
      mask_in   = mask_ff;
      pend_in   = pend_ff;
      reload_in = reload_ff;
      acc_in    = acc_ff;
      rd        = '0;

      // Sub writes outside $00/$01 act as main writes
      wr_main = (item.opcode == OP_MAIN_WRITE) ||
                ((item.opcode == OP_SUB_WRITE) && (item.reg_offset != REG_HOST) &&
                 (item.reg_offset != REG_CTRL));

      if (wr_main) begin
         case (item.reg_offset)
            REG_CTRL: begin
               ctrl_in = item.write_data;
               held_in = ~item.write_data[CTRL_RUN_BIT];
               if (item.write_data[CTRL_RUN_BIT]) begin
                  bus_in = item.write_data[CTRL_BUS_BIT];
               end
            end
            REG_HOST: begin
               host_in = item.write_data;
               if (item.write_data[HOST_REQ_BIT] && mask_ff[LVL_HOST]) begin
                  pend_in[LVL_HOST] = 1'b1;
               end
            end
            REG_MASK: begin
               mask_in = item.write_data;
               if (item.write_data[LVL_HOST] && host_ff[HOST_REQ_BIT]) begin
                  pend_in[LVL_HOST] = 1'b1;
               end
            end
            REG_TIMER: begin
               reload_in = item.write_data;
               acc_in    = '0;
            end
            default: begin
            end
         endcase
      end else begin
         case (opcode_type'(item.opcode))
            OP_SUB_WRITE: begin
               if ((item.reg_offset == REG_CTRL) && !item.write_data[CTRL_RUN_BIT]) begin
                  mask_in   = '0;
                  pend_in   = '0;
                  reload_in = '0;
                  acc_in    = '0;
               end
            end
            OP_READ: begin
               case (item.reg_offset)
                  REG_HOST:  rd = host_ff;
                  REG_CTRL:  rd = ctrl_ff;
                  REG_TIMER: rd = reload_ff;
                  REG_MASK:  rd = mask_ff;
                  default:   rd = '0;
               endcase
            end
            OP_TICK: begin
               if (!held_ff && !bus_ff && (reload_ff != '0)) begin
                  if (sum >= SUM_W'(period)) begin
                     pend_in[LVL_TIMER] = 1'b1;
                     acc_in             = rem[ACC_W-1:0];
                  end else begin
                     acc_in = sum[ACC_W-1:0];
                  end
               end
            end
            OP_ACK: begin
               pend_in[item.irq_level_in] = 1'b0;
               if (item.irq_level_in == LVL_W'(LVL_HOST)) begin
                  host_in[HOST_REQ_BIT] = 1'b0;
               end
            end
            OP_RAISE: begin
               pend_in[item.irq_level_in] = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Freeze the delivered level while the CPU sits in reset
      level_in = held_in ? level_ff : encode(pend_in & mask_in);

      result.read_data      = rd;
      result.irq_level      = level_in;
      result.cpu_reset_held = held_in;
      result.cpu_bus_held   = bus_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_ff   <= '0;
         ctrl_ff   <= '0;
         held_ff   <= 1'b1;
         bus_ff    <= 1'b0;
         mask_ff   <= '0;
         pend_ff   <= '0;
         reload_ff <= '0;
         acc_ff    <= '0;
         level_ff  <= '0;
      end else if (fire) begin
         host_ff   <= host_in;
         ctrl_ff   <= ctrl_in;
         held_ff   <= held_in;
         bus_ff    <= bus_in;
         mask_ff   <= mask_in;
         pend_ff   <= pend_in;
         reload_ff <= reload_in;
         acc_ff    <= acc_in;
         level_ff  <= level_in;
      end
   end

endmodule

>>> sv/sub_cpu_interrupt_timer_controller.sv
// ----------------------------------------------------------------------------
// sub_cpu_interrupt_timer_controller - secondary CPU interrupt and timer gate
// Reset/bus-hold control, host request flag, interrupt mask and pending bits,
// interval timer and level encoder, driven by a stream of bus items.
// ----------------------------------------------------------------------------
// Usage:
//  - The req_ channel carries one item per handshake: main write, sub write,
//    read, timer tick with the elapsed CPU time, acknowledge or raise of a level.
//  - Every accepted item returns exactly one rsp_ item in order: read data
//    (zero except for reads), delivered level and the CPU hold status as
//    they stand after the item.
//  - An accepted item waits in the input register and passes through the
//    core into the result register, where rsp_valid rises.
//  - Throughput is one item per cycle while rsp_stall stays low; the core
//    executes in a single pass, the timer remainder taking at most two
//    compare-subtract steps with the default period unit.
//  - When the receiver stalls, the result register holds its item and the
//    input register keeps one more; req_stall rises only when both are full.
//  - Reset empties both registers, holds the CPU in reset and clears all
//    gate registers and the timer. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sub_cpu_interrupt_timer_controller #(
   parameter int unsigned TIMER_UNIT = sict_pkg::TIMER_UNIT_DEF,
   parameter int unsigned MAX_TICK   = sict_pkg::MAX_TICK_DEF
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   input  logic [9:0] req_tick_cycles,
   input  logic [2:0] req_irq_level_in,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [2:0] rsp_irq_level,
   output logic       rsp_cpu_reset_held,
   output logic       rsp_cpu_bus_held
);
   import sict_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type core_result;
   logic         req_take;
   logic         advance;

   // Advance the held item into the core whenever the result slot frees up
   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      // Keep a stalled result, drop one the receiver has taken
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   sict_core #(
      .TIMER_UNIT (TIMER_UNIT),
      .MAX_TICK   (MAX_TICK)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: input loads on handshake, result on advance, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.opcode       <= req_opcode;
         in_item_ff.reg_offset   <= req_reg_offset;
         in_item_ff.write_data   <= req_write_data;
         in_item_ff.tick_cycles  <= req_tick_cycles;
         in_item_ff.irq_level_in <= req_irq_level_in;
      end
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_item_ff.read_data;
   assign rsp_irq_level      = rsp_item_ff.irq_level;
   assign rsp_cpu_reset_held = rsp_item_ff.cpu_reset_held;
   assign rsp_cpu_bus_held   = rsp_item_ff.cpu_bus_held;

endmodule

>>> sv/sict_checker.sv
// ----------------------------------------------------------------------------
// sict_checker - port-level checks for the interrupt and timer controller
// Watches both channels and the delivered level across consecutive items.
// ----------------------------------------------------------------------------
module sict_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_read_data,
   input logic [2:0] rsp_irq_level,
   input logic       rsp_cpu_reset_held,
   input logic       rsp_cpu_bus_held
);
   logic       in_acc;
   logic       out_acc;
   logic [1:0] inflight_ff;
   logic       prev_valid_ff;
   logic [2:0] prev_level_ff;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff   <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         if (in_acc && !out_acc) begin
            inflight_ff <= inflight_ff + 2'd1;
         end else if (!in_acc && out_acc) begin
            inflight_ff <= inflight_ff - 2'd1;
         end
         if (out_acc) begin
            prev_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_acc) begin
         prev_level_ff <= rsp_irq_level;
      end
   end

   // A stalled result stays and holds its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) &&
         $stable(rsp_irq_level) && $stable(rsp_cpu_reset_held) &&
         $stable(rsp_cpu_bus_held))
      else $error("stalled result changed");

   // No result without an accepted item, never more than two in flight
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      out_acc |-> inflight_ff != 2'd0)
      else $error("result delivered without an item");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      in_acc && !out_acc |-> inflight_ff < 2'd2)
      else $error("more than two items in flight");

   // The level stays frozen across items that end with the CPU in reset
   a_level_frozen: assert property (@(posedge clock) disable iff (reset)
      out_acc && rsp_cpu_reset_held && prev_valid_ff |-> rsp_irq_level == prev_level_ff)
      else $error("level changed while CPU held in reset");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sub_cpu_interrupt_timer_controller sict_checker u_sict_checker (.*);

>>> tb/tb_sub_cpu_interrupt_timer_controller.sv
// ----------------------------------------------------------------------------
// tb_sub_cpu_interrupt_timer_controller - interrupt and timer gate testbench
// Drives register writes, reads, ticks, acknowledges and raises through the
// req_ channel. A short table of directed items runs first, then random
// phases. Every rsp_ item is checked against a behavioral copy of the gate,
// or against the value typed into the table. Each side idles at random in some phases.
// ----------------------------------------------------------------------------
module tb_sub_cpu_interrupt_timer_controller;
   import sict_pkg::*;

   // Opcodes outside the defined set; the block must leave its state alone
   localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

   localparam bit KNOWN = 1'b1;   // expected status typed into the row
   localparam bit PRED  = 1'b0;   // expected status comes from the predictor

   localparam int PHASES       = 4;
   localparam int PHASE_ITEMS  = 212;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 100000;

   typedef struct packed {
      req_item_type it;
      logic         known;
      rsp_item_type rsp;
   } stim_row_type;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_stall;
   logic [OP_W-1:0]  req_opcode       = '0;
   logic [BYTE_W-1:0] req_reg_offset  = '0;
   logic [BYTE_W-1:0] req_write_data  = '0;
   logic [TICK_W-1:0] req_tick_cycles = '0;
   logic [LVL_W-1:0] req_irq_level_in = '0;
   logic             rsp_valid;
   logic             rsp_stall        = 1'b0;
   logic [BYTE_W-1:0] rsp_read_data;
   logic [LVL_W-1:0] rsp_irq_level;
   logic             rsp_cpu_reset_held;
   logic             rsp_cpu_bus_held;

   // Behavioral copy of the gate state
   logic [BYTE_W-1:0] host_req;
   logic [BYTE_W-1:0] cpu_ctrl;
   logic              cpu_held;
   logic              bus_hold;
   logic [BYTE_W-1:0] int_mask;
   logic [BYTE_W-1:0] int_pend;
   logic [BYTE_W-1:0] tmr_word;
   int unsigned       tmr_acc;
   logic [LVL_W-1:0]  cpu_level;

   rsp_item_type due_status_q[$];
   stim_row_type directed_rows[$];

   bit tx_idle = 1'b1;
   bit rx_idle = 1'b1;
   int error_count  = 0;
   int cycle_count  = 0;
   int stall_left   = 0;
   int timer_fires  = 0;
   int results_seen = 0;
   int op_seen[8];

   sub_cpu_interrupt_timer_controller i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_reg_offset     (req_reg_offset),
      .req_write_data     (req_write_data),
      .req_tick_cycles    (req_tick_cycles),
      .req_irq_level_in   (req_irq_level_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_irq_level      (rsp_irq_level),
      .rsp_cpu_reset_held (rsp_cpu_reset_held),
      .rsp_cpu_bus_held   (rsp_cpu_bus_held)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Re-encode levels 6..1 of pending AND mask; freeze while the CPU is held
   function automatic void update_level();
      logic [BYTE_W-1:0] active;
      active = int_pend & int_mask;
      if (!cpu_held) begin
         cpu_level = '0;
         for (int l = 6; l >= 1; l--) begin
            if (active[l] && cpu_level == '0) begin
               cpu_level = LVL_W'(l);
            end
         end
      end
   endfunction

   function automatic void set_pending(input int lvl);
      int_pend[lvl] = 1'b1;
      update_level();
   endfunction

   // Main-side register write; sub writes to other offsets fall through here too
   function automatic void store_main(input logic [BYTE_W-1:0] off,
                                      input logic [BYTE_W-1:0] v);
      logic was_running;
      was_running = cpu_ctrl[CTRL_RUN_BIT];
      case (off)
         REG_CTRL: begin
            cpu_ctrl = v;
            if (v[CTRL_RUN_BIT] && !was_running) begin
               cpu_held = 1'b0;
               update_level();
            end else if (!v[CTRL_RUN_BIT]) begin
               cpu_held = 1'b1;
            end
            // Bus hold follows bit 1 only while the CPU runs
            if (!cpu_held) begin
               bus_hold = v[CTRL_BUS_BIT];
            end
         end
         REG_HOST: begin
            host_req = v;
            if (v[HOST_REQ_BIT] && int_mask[LVL_HOST]) begin
               set_pending(LVL_HOST);
            end
         end
         REG_MASK: begin
            int_mask = v;
            if (v[LVL_HOST] && host_req[HOST_REQ_BIT]) begin
               set_pending(LVL_HOST);
            end
            update_level();
         end
         REG_TIMER: begin
            tmr_word = v;
            tmr_acc  = 0;
         end
         default: ;
      endcase
   endfunction

   // Apply one item to the copy and return the status it leaves behind
   function automatic rsp_item_type predict_gate(input req_item_type it);
      rsp_item_type r;
      int unsigned  period;
      int unsigned  cyc;
      r = '0;
      case (it.opcode)
         OP_MAIN_WRITE: store_main(it.reg_offset, it.write_data);
         OP_SUB_WRITE: begin
            if (it.reg_offset == REG_CTRL) begin
               // Sub-side stop clears mask, pending bits and the timer
               if (!it.write_data[CTRL_RUN_BIT]) begin
                  int_mask = '0;
                  int_pend = '0;
                  update_level();
                  tmr_word = '0;
                  tmr_acc  = 0;
               end
            end else if (it.reg_offset != REG_HOST) begin
               store_main(it.reg_offset, it.write_data);
            end
         end
         OP_READ: begin
            case (it.reg_offset)
               REG_HOST:  r.read_data = host_req;
               REG_CTRL:  r.read_data = cpu_ctrl;
               REG_TIMER: r.read_data = tmr_word;
               REG_MASK:  r.read_data = int_mask;
               default:   r.read_data = '0;
            endcase
         end
         OP_TICK: begin
            if (!cpu_held && !bus_hold && tmr_word != '0) begin
               cyc = 32'(it.tick_cycles);
               if (cyc > MAX_TICK_DEF) begin
                  cyc = MAX_TICK_DEF;
               end
               tmr_acc = tmr_acc + cyc;
               period  = (32'(tmr_word) + 1) * TIMER_UNIT_DEF;
               // Several periods in one tick still set a single pending bit
               if (tmr_acc >= period) begin
                  tmr_acc = tmr_acc % period;
                  set_pending(LVL_TIMER);
                  timer_fires++;
               end
               tmr_acc = tmr_acc & ((1 << ACC_W) - 1);
            end
         end
         OP_ACK: begin
            int_pend[it.irq_level_in] = 1'b0;
            if (it.irq_level_in == LVL_W'(LVL_HOST)) begin
               host_req[HOST_REQ_BIT] = 1'b0;
            end
            update_level();
         end
         OP_RAISE: set_pending(int'(it.irq_level_in));
         default: ;
      endcase
      r.irq_level      = cpu_level;
      r.cpu_reset_held = cpu_held;
      r.cpu_bus_held   = bus_hold;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------

   // Idle for a drawn gap when tx_idle is set, present the item, hold it until accepted
   task automatic send_item(input req_item_type it, input bit known,
                            input rsp_item_type known_rsp);
      int           gap;
      rsp_item_type want;
      gap = tx_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= it.opcode;
      req_reg_offset   <= it.reg_offset;
      req_write_data   <= it.write_data;
      req_tick_cycles  <= it.tick_cycles;
      req_irq_level_in <= it.irq_level_in;
      do @(posedge clock); while (req_stall);
      want = predict_gate(it);
      if (known) begin
         want = known_rsp;
      end
      due_status_q.push_back(want);
      op_seen[it.opcode]++;
   endtask

   function automatic void add_row(input logic [OP_W-1:0] op,
                                   input logic [BYTE_W-1:0] off,
                                   input logic [BYTE_W-1:0] data,
                                   input logic [TICK_W-1:0] cyc,
                                   input logic [LVL_W-1:0] lvl,
                                   input bit known,
                                   input logic [BYTE_W-1:0] rd,
                                   input logic [LVL_W-1:0] lv,
                                   input logic rh, input logic bh);
      stim_row_type row;
      row.it    = '{op, off, data, cyc, lvl};
      row.known = known;
      row.rsp   = '{rd, lv, rh, bh};
      directed_rows.push_back(row);
   endfunction

   // ------------------------------------------------------------------------
   // Receiver and checker
   // ------------------------------------------------------------------------

   // Compare each accepted result with the oldest expectation, then stall
   // for a drawn number of cycles when rx_idle is set
   always @(posedge clock) begin
      rsp_item_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         if (stall_left == 0) begin
            rsp_stall <= 1'b0;
         end
      end else if (rsp_valid && !rsp_stall) begin
         results_seen++;
         if (due_status_q.size() == 0) begin
            $display("%0t unexpected result: read_data %0h irq_level %0d", $time,
                     rsp_read_data, rsp_irq_level);
            error_count++;
         end else begin
            w = due_status_q.pop_front();
            if (rsp_read_data !== w.read_data) begin
               $display("%0t read_data: expected %0h, got %0h", $time,
                        w.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_irq_level !== w.irq_level) begin
               $display("%0t irq_level: expected %0d, got %0d", $time,
                        w.irq_level, rsp_irq_level);
               error_count++;
            end
            if (rsp_cpu_reset_held !== w.cpu_reset_held) begin
               $display("%0t cpu_reset_held: expected %0b, got %0b", $time,
                        w.cpu_reset_held, rsp_cpu_reset_held);
               error_count++;
            end
            if (rsp_cpu_bus_held !== w.cpu_bus_held) begin
               $display("%0t cpu_bus_held: expected %0b, got %0b", $time,
                        w.cpu_bus_held, rsp_cpu_bus_held);
               error_count++;
            end
         end
         stall_left = rx_idle ? $urandom_range(0, 3) : 0;
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
         end
      end
   end

   // Watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  due_status_q.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      req_item_type it;
      rsp_item_type none;
      int           pick;

      none     = '0;
      host_req = '0;
      cpu_ctrl = '0;
      cpu_held = 1'b1;
      bus_hold = 1'b0;
      int_mask = '0;
      int_pend = '0;
      tmr_word = '0;
      tmr_acc  = 0;
      cpu_level = '0;
      foreach (op_seen[k]) op_seen[k] = 0;

      // Directed table: values after reset, holds, releases, request and
      // timer paths, sub-side stop, unused levels and undefined opcodes
      //      op             offset     data   cycles    lvl   chk    rd    lvl rst bus
      add_row(OP_READ,       REG_CTRL,  8'h00, 10'd0,    3'd0, KNOWN, 8'h00, 3'd0, 1, 0);
      add_row(OP_READ,       8'hFF,     8'hFF, 10'd1023, 3'd7, KNOWN, 8'h00, 3'd0, 1, 0);
      // Tick while the CPU is held does nothing
      add_row(OP_TICK,       REG_HOST,  8'h00, 10'd1023, 3'd0, KNOWN, 8'h00, 3'd0, 1, 0);
      add_row(OP_MAIN_WRITE, REG_MASK,  8'hFF, 10'd0,    3'd0, KNOWN, 8'h00, 3'd0, 1, 0);
      // Level stays frozen while held, then shows on release
      add_row(OP_RAISE,      REG_HOST,  8'h00, 10'd0,    3'd6, KNOWN, 8'h00, 3'd0, 1, 0);
      add_row(OP_MAIN_WRITE, REG_CTRL,  8'h01, 10'd0,    3'd0, KNOWN, 8'h00, 3'd6, 0, 0);
      add_row(OP_MAIN_WRITE, REG_CTRL,  8'h03, 10'd0,    3'd0, KNOWN, 8'h00, 3'd6, 0, 1);
      add_row(OP_TICK,       REG_HOST,  8'h00, 10'd1023, 3'd0, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_MAIN_WRITE, REG_CTRL,  8'h01, 10'd0,    3'd0, KNOWN, 8'h00, 3'd6, 0, 0);
      add_row(OP_READ,       REG_MASK,  8'h00, 10'd0,    3'd0, KNOWN, 8'hFF, 3'd6, 0, 0);
      add_row(OP_ACK,        REG_HOST,  8'h00, 10'd0,    3'd6, KNOWN, 8'h00, 3'd0, 0, 0);
      // Host request raises level 2; acknowledge drops the request flag
      add_row(OP_MAIN_WRITE, REG_HOST,  8'h01, 10'd0,    3'd0, KNOWN, 8'h00, 3'd2, 0, 0);
      add_row(OP_ACK,        REG_HOST,  8'h00, 10'd0,    3'd2, KNOWN, 8'h00, 3'd0, 0, 0);
      // Masked request raises level 2 later on unmask
      add_row(OP_MAIN_WRITE, REG_MASK,  8'h00, 10'd0,    3'd0, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_MAIN_WRITE, REG_HOST,  8'h01, 10'd0,    3'd0, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_MAIN_WRITE, REG_MASK,  8'h04, 10'd0,    3'd0, KNOWN, 8'h00, 3'd2, 0, 0);
      // Timer: one period of 2*unit split over two ticks
      add_row(OP_MAIN_WRITE, REG_TIMER, 8'h01, 10'd0,    3'd0, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_TICK,       REG_HOST,  8'h00, 10'd769,  3'd0, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_TICK,       REG_HOST,  8'h00, 10'd1,    3'd0, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_MAIN_WRITE, REG_MASK,  8'hFF, 10'd0,    3'd0, KNOWN, 8'h00, 3'd3, 0, 0);
      add_row(OP_MAIN_WRITE, REG_TIMER, 8'hFF, 10'd0,    3'd0, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_TICK,       REG_HOST,  8'h00, 10'd1023, 3'd0, PRED,  8'h00, 3'd0, 0, 0);
      // Sub side: $00 ignored, stop clears, other offsets act as main
      add_row(OP_SUB_WRITE,  REG_HOST,  8'hFF, 10'd0,    3'd0, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_SUB_WRITE,  REG_CTRL,  8'h00, 10'd0,    3'd0, KNOWN, 8'h00, 3'd0, 0, 0);
      add_row(OP_SUB_WRITE,  REG_MASK,  8'h04, 10'd0,    3'd0, KNOWN, 8'h00, 3'd2, 0, 0);
      // Unused levels 0 and 7, undefined opcodes
      add_row(OP_RAISE,      REG_HOST,  8'h00, 10'd0,    3'd7, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_ACK,        REG_HOST,  8'h00, 10'd0,    3'd0, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_UNDEF_LO,   REG_CTRL,  8'h00, 10'd0,    3'd2, PRED,  8'h00, 3'd0, 0, 0);
      add_row(OP_UNDEF_HI,   REG_MASK,  8'hFF, 10'd0,    3'd2, PRED,  8'h00, 3'd0, 0, 0);
      // Hold reset again; the delivered level stays where it was
      add_row(OP_MAIN_WRITE, REG_CTRL,  8'h00, 10'd0,    3'd0, KNOWN, 8'h00, 3'd2, 1, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].it, directed_rows[i].known, directed_rows[i].rsp);
      end

      // Random phases; drain between them and vary who idles
      for (int ph = 0; ph < PHASES; ph++) begin
         req_valid <= 1'b0;
         while (due_status_q.size() != 0) @(posedge clock);
         tx_idle = (ph == 0) || (ph == 2);
         rx_idle = (ph == 0) || (ph == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            it.write_data   = BYTE_W'($urandom_range(0, 255));
            it.tick_cycles  = TICK_W'($urandom_range(0, 1023));
            it.irq_level_in = LVL_W'($urandom_range(0, 7));
            // Mostly the four live registers, sometimes any offset
            if ($urandom_range(0, 4) == 0) begin
               it.reg_offset = BYTE_W'($urandom_range(0, 255));
            end else begin
               case ($urandom_range(0, 3))
                  0:       it.reg_offset = REG_HOST;
                  1:       it.reg_offset = REG_CTRL;
                  2:       it.reg_offset = REG_TIMER;
                  default: it.reg_offset = REG_MASK;
               endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 28)      it.opcode = OP_MAIN_WRITE;
            else if (pick < 38) it.opcode = OP_SUB_WRITE;
            else if (pick < 53) it.opcode = OP_READ;
            else if (pick < 77) it.opcode = OP_TICK;
            else if (pick < 88) it.opcode = OP_ACK;
            else if (pick < 99) it.opcode = OP_RAISE;
            else                it.opcode = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
            // Keep the CPU running most of the time so ticks count
            if (it.reg_offset == REG_CTRL && $urandom_range(0, 99) < 85) begin
               it.write_data[CTRL_RUN_BIT] = 1'b1;
            end
            // Short timer periods so level 3 fires often
            if (it.reg_offset == REG_TIMER && $urandom_range(0, 9) < 7) begin
               it.write_data = BYTE_W'($urandom_range(0, 3));
            end
            send_item(it, PRED, none);
         end
      end

      // Drop valid, wait for the last results, then let the pipe settle
      req_valid <= 1'b0;
      while (due_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d results: %0d main writes, %0d sub writes, %0d reads, %0d ticks",
               results_seen, op_seen[OP_MAIN_WRITE], op_seen[OP_SUB_WRITE],
               op_seen[OP_READ], op_seen[OP_TICK]);
      $display("  %0d acks, %0d raises, %0d undefined ops, %0d timer expiries, %0d errors",
               op_seen[OP_ACK], op_seen[OP_RAISE], op_seen[OP_UNDEF_LO] + op_seen[OP_UNDEF_HI],
               timer_fires, error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
